/* design/tmps_pkg.sv */
// Shared types and constants for the triangular matrix product sum block.
package tmps_pkg;

    localparam int DEFAULT_MAX_DIM = 16;
    localparam int EL_W            = 16;  // Q4.12 element
    localparam int C_W             = 64;  // Q28.36 result
    localparam int SIZE_W          = 5;
    localparam int IDX_W           = 4;   // row and col fields
    localparam int AA_SHIFT        = 12;  // Q8.24 to Q28.36
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ACT_WR_A    = 2'd0,
        ACT_WR_B    = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_RD_C    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AB,
        ST_DRAIN_AB,
        ST_ABB,
        ST_AA,
        ST_DRAIN_C
    } state_t;

    typedef enum logic [1:0] {
        OP_AB,
        OP_ABB,
        OP_AA
    } op_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic aa;
    } mac_ctl_t;

endpackage

/* design/triangular_matrix_product_sum.sv */
// Write/read: a read of C returns its result on the following cycle.
// Compute: one multiply-accumulate per cycle on the single shared multiplier,
// except while the pipeline drains between phases and at the end; busy meanwhile.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n, asynchronous) clears control and sets matrix_size to 16; stores are
// not cleared and hold undefined data until written.
module triangular_matrix_product_sum #(
    parameter int MAX_DIM = tmps_pkg::DEFAULT_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [tmps_pkg::IDX_W-1:0]          row,
    input  logic [tmps_pkg::IDX_W-1:0]          col,
    input  logic signed [tmps_pkg::EL_W-1:0]    element_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmps_pkg::SIZE_W-1:0]         cfg_data,
    output logic                                out_valid,
    output logic                                kind,
    output logic [tmps_pkg::IDX_W-1:0]          out_row,
    output logic [tmps_pkg::IDX_W-1:0]          out_col,
    output logic signed [tmps_pkg::C_W-1:0]     c_value
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int PW    = 32 + 2 * IW;
    localparam int EW    = tmps_pkg::EL_W;
    localparam int CW    = tmps_pkg::C_W;

    // configuration
    logic [tmps_pkg::SIZE_W-1:0] matrix_size_reg;
    int                          n_eff;
    logic [IW-1:0]               n_m1;

    // request decode
    logic accept;
    logic in_store;
    logic wr_a;
    logic wr_b;
    logic rd_c;
    logic go;
    logic [AW-1:0] in_addr;

    // sequencer
    tmps_pkg::state_t state_reg;
    tmps_pkg::state_t state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] lim;
    logic          empty;
    logic          issue;
    logic          issue_first;
    logic          issue_last;
    tmps_pkg::op_t issue_op;

    // memories and read addresses
    logic signed [EW-1:0] a_mem  [DEPTH];
    logic signed [EW-1:0] b_mem  [DEPTH];
    logic signed [PW-1:0] ab_mem [DEPTH];
    logic signed [CW-1:0] c_mem  [DEPTH];
    logic [AW-1:0] a0_addr;
    logic [AW-1:0] a1_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] ab_addr;

    // operand stage
    logic signed [EW-1:0] a0_rd_reg;
    logic signed [EW-1:0] a1_rd_reg;
    logic signed [EW-1:0] b_rd_reg;
    logic signed [PW-1:0] ab_rd_reg;
    logic          s1_valid_reg;
    logic          s1_first_reg;
    logic          s1_last_reg;
    tmps_pkg::op_t s1_op_reg;
    logic [IW-1:0] s1_i_reg;
    logic [IW-1:0] s1_j_reg;

    // accumulate stage
    logic          s2_valid_reg;
    logic          s2_last_reg;
    tmps_pkg::op_t s2_op_reg;
    logic [IW-1:0] s2_i_reg;
    logic [IW-1:0] s2_j_reg;
    logic          wr_res;
    logic [AW-1:0] res_addr;

    tmps_pkg::mac_ctl_t   mac_ctl;
    logic signed [PW-1:0] mac_x;
    logic signed [EW-1:0] mac_y;
    logic signed [CW-1:0] mac_sum;

    // result registers
    logic                       out_valid_reg, out_valid_next;
    logic                       kind_reg, kind_next;
    logic [tmps_pkg::IDX_W-1:0] out_row_reg, out_row_next;
    logic [tmps_pkg::IDX_W-1:0] out_col_reg, out_col_next;
    logic                       in_range_reg, in_range_next;
    logic signed [CW-1:0]       c_rd_reg;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= tmps_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            matrix_size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_eff = 1;
        end
        else if (int'(matrix_size_reg) > MAX_DIM)
        begin
            n_eff = MAX_DIM;
        end
        else
        begin
            n_eff = int'(matrix_size_reg);
        end
        n_m1 = IW'(n_eff - 1);
    end

    // --------------------------------------------------------------- decode
    assign accept   = start && !busy;
    assign in_store = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign in_addr  = {IW'(row), IW'(col)};

    always_comb
    begin
        wr_a = 1'b0;
        wr_b = 1'b0;
        rd_c = 1'b0;
        go   = 1'b0;
        unique case (tmps_pkg::action_t'(action))
            tmps_pkg::ACT_WR_A:    wr_a = accept && in_store;
            tmps_pkg::ACT_WR_B:    wr_b = accept && in_store;
            tmps_pkg::ACT_COMPUTE: go   = accept;
            tmps_pkg::ACT_RD_C:    rd_c = accept;
            default:               ;
        endcase
    end

    // ------------------------------------------------------------ sequencer
    assign lim   = (i_reg < j_reg) ? i_reg : j_reg;
    assign empty = !s1_valid_reg && !s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmps_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmps_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    state_next = tmps_pkg::ST_AB;
                end
            end
            tmps_pkg::ST_AB:
            begin
                if (k_reg == n_m1 && j_reg == n_m1 && i_reg == n_m1)
                begin
                    state_next = tmps_pkg::ST_DRAIN_AB;
                end
            end
            tmps_pkg::ST_DRAIN_AB:
            begin
                if (empty)
                begin
                    state_next = tmps_pkg::ST_ABB;
                end
            end
            tmps_pkg::ST_ABB:
            begin
                if (k_reg == n_m1)
                begin
                    state_next = tmps_pkg::ST_AA;
                end
            end
            tmps_pkg::ST_AA:
            begin
                if (k_reg == lim)
                begin
                    state_next = (i_reg == n_m1 && j_reg == n_m1) ? tmps_pkg::ST_DRAIN_C
                                                                  : tmps_pkg::ST_ABB;
                end
            end
            tmps_pkg::ST_DRAIN_C:
            begin
                if (empty)
                begin
                    state_next = tmps_pkg::ST_IDLE;
                end
            end
            default: state_next = tmps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != tmps_pkg::ST_IDLE);
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        issue       = 1'b0;
        issue_first = 1'b0;
        issue_last  = 1'b0;
        issue_op    = tmps_pkg::OP_AB;
        unique case (state_reg)
            tmps_pkg::ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
            end
            tmps_pkg::ST_AB:
            begin
                issue       = 1'b1;
                issue_first = (k_reg == i_reg);
                issue_last  = (k_reg == n_m1);
                issue_op    = tmps_pkg::OP_AB;
                if (k_reg == n_m1)
                begin
                    // upper triangle: next row starts its sum at the diagonal
                    if (j_reg == n_m1)
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = '0;
                        k_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        k_next = i_reg;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            tmps_pkg::ST_DRAIN_AB:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
            end
            tmps_pkg::ST_ABB:
            begin
                issue       = 1'b1;
                issue_first = (k_reg == '0);
                issue_op    = tmps_pkg::OP_ABB;
                k_next      = (k_reg == n_m1) ? '0 : k_reg + 1'b1;
            end
            tmps_pkg::ST_AA:
            begin
                issue      = 1'b1;
                issue_last = (k_reg == lim);
                issue_op   = tmps_pkg::OP_AA;
                if (k_reg == lim)
                begin
                    k_next = '0;
                    if (j_reg == n_m1)
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            tmps_pkg::ST_DRAIN_C: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------- memories
    assign a0_addr = (state_reg == tmps_pkg::ST_AA) ? {k_reg, i_reg} : {i_reg, k_reg};
    assign a1_addr = {k_reg, j_reg};
    assign b_addr  = (state_reg == tmps_pkg::ST_ABB) ? {j_reg, k_reg} : {k_reg, j_reg};
    assign ab_addr = {i_reg, k_reg};

    assign wr_res   = s2_valid_reg && s2_last_reg;
    assign res_addr = {s2_i_reg, s2_j_reg};

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[in_addr] <= element_value;
        end
        a0_rd_reg <= a_mem[a0_addr];
        a1_rd_reg <= a_mem[a1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            b_mem[in_addr] <= element_value;
        end
        b_rd_reg <= b_mem[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_res && s2_op_reg == tmps_pkg::OP_AB)
        begin
            ab_mem[res_addr] <= PW'(mac_sum);
        end
        ab_rd_reg <= ab_mem[ab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_res && s2_op_reg != tmps_pkg::OP_AB)
        begin
            c_mem[res_addr] <= mac_sum;
        end
        if (rd_c)
        begin
            c_rd_reg <= c_mem[in_addr];
        end
    end

    // ------------------------------------------------------------- pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= issue_first;
        s1_last_reg  <= issue_last;
        s1_op_reg    <= issue_op;
        s1_i_reg     <= i_reg;
        s1_j_reg     <= j_reg;
        s2_last_reg  <= s1_last_reg;
        s2_op_reg    <= s1_op_reg;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;
    end

    always_comb
    begin
        mac_ctl.valid = s1_valid_reg;
        mac_ctl.first = s1_first_reg;
        mac_ctl.aa    = (s1_op_reg == tmps_pkg::OP_AA);
        if (s1_op_reg == tmps_pkg::OP_ABB)
        begin
            mac_x = ab_rd_reg;
        end
        else
        begin
            mac_x = {{(PW-EW){a0_rd_reg[EW-1]}}, a0_rd_reg};
        end
        mac_y = (s1_op_reg == tmps_pkg::OP_AA) ? a1_rd_reg : b_rd_reg;
    end

    tmps_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .x     (mac_x),
        .y     (mac_y),
        .sum   (mac_sum)
    );

    // -------------------------------------------------------------- results
    always_comb
    begin
        out_valid_next = 1'b0;
        kind_next      = kind_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        in_range_next  = in_range_reg;
        if (rd_c)
        begin
            out_valid_next = 1'b1;
            kind_next      = tmps_pkg::KIND_READ;
            out_row_next   = row;
            out_col_next   = col;
            in_range_next  = (int'(row) < n_eff) && (int'(col) < n_eff);
        end
        else if (state_reg == tmps_pkg::ST_DRAIN_C && empty)
        begin
            out_valid_next = 1'b1;
            kind_next      = tmps_pkg::KIND_DONE;
            out_row_next   = '0;
            out_col_next   = '0;
            in_range_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        in_range_reg <= in_range_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign c_value   = (kind_reg == tmps_pkg::KIND_READ && in_range_reg) ? c_rd_reg : '0;

`ifndef NO_ASSERTIONS
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == tmps_pkg::ST_IDLE)
        else $error("result strobe while computing");

    a_writeback_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_res |-> (s2_i_reg <= n_m1 && s2_j_reg <= n_m1))
        else $error("writeback outside matrix size");

    a_busy_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action == tmps_pkg::ACT_COMPUTE))
        else $error("busy raised without a compute request");

    a_done_follows_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmps_pkg::ST_DRAIN_C && empty)
            |=> (out_valid && kind == tmps_pkg::KIND_DONE))
        else $error("missing done result after compute");
`endif

endmodule

/* design/tmps_mac.sv */
// Shared multiplier with saturating 64-bit accumulator.
module tmps_mac #(
    parameter int MAX_DIM = tmps_pkg::DEFAULT_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tmps_pkg::mac_ctl_t                  ctl,
    input  logic signed [32+2*$clog2(MAX_DIM)-1:0] x,
    input  logic signed [tmps_pkg::EL_W-1:0]    y,
    output logic signed [tmps_pkg::C_W-1:0]     sum
);

    localparam int IW  = $clog2(MAX_DIM);
    localparam int PW  = 32 + 2 * IW;
    localparam int PRW = PW + tmps_pkg::EL_W;
    localparam int CW  = tmps_pkg::C_W;

    tmps_pkg::mac_ctl_t      ctl_reg;
    logic signed [PRW-1:0]   prod_reg;
    logic signed [PRW-1:0]   prod_next;
    logic signed [CW-1:0]    acc_reg;
    logic signed [CW-1:0]    term;
    logic signed [CW-1:0]    base;
    logic signed [CW:0]      wide;

    assign prod_next = x * y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.valid)
        begin
            acc_reg <= sum;
        end
    end

    always_comb
    begin
        term = {{(CW-PRW){prod_reg[PRW-1]}}, prod_reg};
        if (ctl_reg.aa)
        begin
            term = term <<< tmps_pkg::AA_SHIFT;
        end
        base = ctl_reg.first ? '0 : acc_reg;
        wide = {base[CW-1], base} + {term[CW-1], term};
        // clamp when the carry out disagrees with the sign bit
        if (wide[CW] != wide[CW-1])
        begin
            sum = wide[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            sum = wide[CW-1:0];
        end
    end

endmodule

/* bench/tb_triangular_matrix_product_sum.sv */
// Self-checking testbench for triangular_matrix_product_sum: directed steps, then random phases.
module tb_triangular_matrix_product_sum;
    import tmps_pkg::*;

    localparam int MAX_DIM = DEFAULT_MAX_DIM;
    localparam int SETTLE  = 8;
    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        r;
        logic [IDX_W-1:0]        c;
        logic signed [C_W-1:0]   val;
    } c_result_t;

    typedef struct packed {
        logic                    is_size;
        logic [SIZE_W-1:0]       size;
        action_t                 act;
        logic [IDX_W-1:0]        r;
        logic [IDX_W-1:0]        c;
        logic signed [EL_W-1:0]  v;
        logic                    zero_expected;
    } step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              action = ACT_WR_A;
    logic [IDX_W-1:0]        row = '0;
    logic [IDX_W-1:0]        col = '0;
    logic signed [EL_W-1:0]  element_value = '0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [SIZE_W-1:0]       cfg_data = '0;
    logic                    out_valid;
    logic                    kind;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [C_W-1:0]   c_value;

    // mirror of the block's state
    logic [SIZE_W-1:0]       size_reg = SIZE_RESET;
    logic signed [EL_W-1:0]  a_mem [MAX_DIM][MAX_DIM];
    logic signed [EL_W-1:0]  b_mem [MAX_DIM][MAX_DIM];
    longint                  ab_mem [MAX_DIM][MAX_DIM];
    longint                  c_mem [MAX_DIM][MAX_DIM];
    bit                      c_ok [MAX_DIM][MAX_DIM];

    c_result_t pending_results[$];
    step_t     steps[$];

    bit gaps_on = 1'b1;
    int mismatches, results_seen, requests, computes, reads, size_writes, largest_n;

    triangular_matrix_product_sum #(.MAX_DIM(MAX_DIM)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .kind          (kind),
        .out_row       (out_row),
        .out_col       (out_col),
        .c_value       (c_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int dim_in_use(logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_DIM)
            return MAX_DIM;
        return int'(s);
    endfunction

    function automatic longint sat_sum(longint x, longint y);
        longint s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63])
            return x[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    // below the diagonal A reads as zero whatever was stored
    function automatic longint upper_a(int r, int c);
        return (r > c) ? 0 : longint'(a_mem[r][c]);
    endfunction

    task automatic form_product_sum(int n);
        longint acc;
        int lim;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = i; k < n; k++)
                    acc += upper_a(i, k) * longint'(b_mem[k][j]);
                ab_mem[i][j] = acc;
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                lim = (i < j) ? i : j;
                for (int k = 0; k < n; k++)
                    acc = sat_sum(acc, ab_mem[i][k] * longint'(b_mem[j][k]));
                for (int k = 0; k <= lim; k++)
                    acc = sat_sum(acc, (upper_a(k, i) * upper_a(k, j)) <<< AA_SHIFT);
                c_mem[i][j] = acc;
                c_ok[i][j]  = 1'b1;
            end
    endtask

    function automatic logic signed [EL_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return EL_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // one request; the expectation is taken at the edge that accepts it
    task automatic send_request(action_t act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                logic signed [EL_W-1:0] v, bit zero_expected);
        c_result_t want;
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start         <= 1'b1;
        action        <= act;
        row           <= r;
        col           <= c;
        element_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = dim_in_use(size_reg);
        requests++;
        case (act)
            ACT_WR_A: a_mem[r][c] = v;
            ACT_WR_B: b_mem[r][c] = v;
            ACT_COMPUTE:
            begin
                form_product_sum(n);
                computes++;
                if (n > largest_n)
                    largest_n = n;
                want = '{kind: KIND_DONE, r: '0, c: '0, val: '0};
            end
            default:
            begin
                reads++;
                want = '{kind: KIND_READ, r: r, c: c,
                         val: (r < n && c < n) ? c_mem[r][c] : 0};
            end
        endcase
        if (act == ACT_COMPUTE || act == ACT_RD_C)
        begin
            if (zero_expected)
                want.val = '0;
            pending_results.push_back(want);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_reg = s;
        size_writes++;
    endtask

    always @(posedge clk)
    begin
        c_result_t want;
        if (rst_n && out_valid)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, c_value", c_value, 0);
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (out_row !== want.r)
                    report_mismatch("out_row", out_row, want.r);
                if (out_col !== want.c)
                    report_mismatch("out_col", out_col, want.c);
                if (c_value !== want.val)
                    report_mismatch("c_value", c_value, want.val);
            end
        end
    end

    initial
    begin
        step_t st;
        action_t act;
        logic [IDX_W-1:0] r, c;
        logic [SIZE_W-1:0] sz;
        int n, sel, big_left;

        // is_size, size, act, row, col, value, zero_expected
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd15, 4'd15, 16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd15, 4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_WR_A,    4'd0,  4'd0,  16'sh7FFF,  1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_WR_A,    4'd3,  4'd1,  16'sh7FFF,  1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_WR_A,    4'd1,  4'd1,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_WR_B,    4'd1,  4'd2,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_WR_B,    4'd15, 4'd15, 16'sh7FFF,  1'b0});
        // size 0 behaves as 1
        steps.push_back(step_t'{1'b1, 5'd0,  ACT_WR_A,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd1,  4'd0,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd0,  4'd15, 16'sd0,     1'b1});
        // sizes above the maximum clamp to it
        steps.push_back(step_t'{1'b1, 5'd31, ACT_WR_A,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd3,  4'd1,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd1,  4'd3,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b1, 5'd17, ACT_WR_A,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd15, 4'd15, 16'sd0,     1'b0});
        steps.push_back(step_t'{1'b1, 5'd3,  ACT_WR_A,    4'd0,  4'd0,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd2,  4'd2,  16'sd0,     1'b0});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd3,  4'd3,  16'sd0,     1'b1});
        steps.push_back(step_t'{1'b0, 5'd0,  ACT_RD_C,    4'd15, 4'd15, 16'sd0,     1'b1});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores with the most negative element so no compute sees unwritten data
        for (int i = 0; i < MAX_DIM; i++)
            for (int j = 0; j < MAX_DIM; j++)
            begin
                send_request(ACT_WR_A, i, j, 16'sh8000, 1'b0);
                send_request(ACT_WR_B, i, j, 16'sh8000, 1'b0);
            end

        foreach (steps[s])
        begin
            st = steps[s];
            if (st.is_size)
            begin
                wait_idle();
                write_size(st.size);
            end
            else
                send_request(st.act, st.r, st.c, st.v, st.zero_expected);
        end

        big_left = 2;
        for (int ph = 0; ph < 12; ph++)
        begin
            gaps_on = (ph < 10);
            wait_idle();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                sz = '0;
            else if (sel == 1 && big_left > 0)
            begin
                sz = $urandom_range(16, 31);
                big_left--;
            end
            else
                sz = $urandom_range(1, 8);
            write_size(sz);
            n = dim_in_use(sz);
            if ($urandom_range(0, 3) != 0)
            begin
                // load, compute, read back
                repeat ($urandom_range(2, 6))
                begin
                    act = $urandom_range(0, 1) ? ACT_WR_B : ACT_WR_A;
                    r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
                    c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
                    send_request(act, r, c, rand_element(), 1'b0);
                end
                send_request(ACT_COMPUTE, $urandom, $urandom, rand_element(), 1'b0);
                repeat ($urandom_range(2, 5))
                begin
                    r = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
                    c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
                    send_request(ACT_RD_C, r, c, rand_element(), 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(4, 10))
                begin
                    act = action_t'($urandom_range(0, 3));
                    r = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                    // never read a C entry that no compute has written
                    if (act == ACT_RD_C && r < n && c < n && !c_ok[r][c])
                        act = ACT_WR_B;
                    send_request(act, r, c, rand_element(), 1'b0);
                end
            end
        end

        wait_idle();
        $display("Covered %0d requests: %0d computes (n up to %0d), %0d reads of C, %0d size writes.",
                 requests, computes, largest_n, reads, size_writes);
        $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
